// ===== design/sspr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo status packet receiver package
// Shared constants and the frame phase type of the status frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sspr_pkg;

  localparam int NUM_SERVOS = 16;
  localparam int SERVO_IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  localparam int OUT_TDATA_W = 32;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HDR2   = 3'd1,
    PH_ID     = 3'd2,
    PH_LEN    = 3'd3,
    PH_ERR    = 3'd4,
    PH_POS_LO = 3'd5,
    PH_POS_HI = 3'd6,
    PH_CSUM   = 3'd7
  } phase_t;

endpackage

`default_nettype wire

// ===== design/servo_status_packet_receiver_core.sv =====
// ----------------------------------------------------------------------------
// Servo status packet receiver core
// Hunts for the two-byte header, collects an eight-byte status frame, checks
// its checksum and keeps the last good position of each servo.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless the input side stalls. Each byte is
// registered on input, then a single stage updates the frame phase and
// checksum, and the checksum byte of a frame loads the result register. The
// frame result enters the output register when the checksum byte leaves the
// input register; the input side stalls only while a result waits in the
// output register and the downstream side is not ready.
`default_nettype none

module servo_status_packet_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [sspr_pkg::OUT_TDATA_W-1:0] out_tdata
  // out_tdata: [7:0] servo_id, [23:8] position, [24] checksum_ok, [25] stored,
  // [31:26] zero
);

  logic                     in_vld_r;
  logic [7:0]               in_byte_r;
  logic                     proc_go;
  logic                     frame_done;

  sspr_pkg::phase_t         phase_r, phase_nxt;
  logic [7:0]               frame_id_r, frame_id_nxt;
  logic [7:0]               sum_r, sum_nxt;
  logic [7:0]               pos_lo_r, pos_lo_nxt;
  logic [7:0]               pos_hi_r, pos_hi_nxt;

  logic [7:0]               expect_sum;
  logic                     csum_ok;
  logic                     id_fits;
  logic                     do_store;
  logic [15:0]              frame_pos;
  logic [sspr_pkg::SERVO_IDX_W-1:0] store_idx;

  logic [15:0]              pos_table_r [sspr_pkg::NUM_SERVOS];

  logic                     out_vld_r;
  logic [7:0]               out_id_r;
  logic [15:0]              out_pos_r;
  logic                     out_ok_r;
  logic                     out_stored_r;

  assign proc_go   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  assign expect_sum = sspr_pkg::HEADER_BYTE - sum_r;
  assign csum_ok    = (expect_sum == in_byte_r);
  assign id_fits    = (frame_id_r < 8'(sspr_pkg::NUM_SERVOS));
  assign frame_pos  = {pos_hi_r, pos_lo_r};
  assign store_idx  = frame_id_r[sspr_pkg::SERVO_IDX_W-1:0];

  always_comb begin
    phase_nxt    = phase_r;
    frame_id_nxt = frame_id_r;
    sum_nxt      = sum_r;
    pos_lo_nxt   = pos_lo_r;
    pos_hi_nxt   = pos_hi_r;
    frame_done   = 1'b0;
    do_store     = 1'b0;
    if (proc_go) begin
      unique case (phase_r)
        sspr_pkg::PH_HUNT: begin
          if (in_byte_r == sspr_pkg::HEADER_BYTE) begin
            phase_nxt = sspr_pkg::PH_HDR2;
          end
        end
        sspr_pkg::PH_HDR2: begin
          phase_nxt = (in_byte_r == sspr_pkg::HEADER_BYTE) ? sspr_pkg::PH_ID
                                                           : sspr_pkg::PH_HUNT;
        end
        sspr_pkg::PH_ID: begin
          frame_id_nxt = in_byte_r;
          sum_nxt      = in_byte_r;
          phase_nxt    = sspr_pkg::PH_LEN;
        end
        sspr_pkg::PH_LEN: begin
          sum_nxt   = sum_r + in_byte_r;
          phase_nxt = sspr_pkg::PH_ERR;
        end
        sspr_pkg::PH_ERR: begin
          sum_nxt   = sum_r + in_byte_r;
          phase_nxt = sspr_pkg::PH_POS_LO;
        end
        sspr_pkg::PH_POS_LO: begin
          pos_lo_nxt = in_byte_r;
          sum_nxt    = sum_r + in_byte_r;
          phase_nxt  = sspr_pkg::PH_POS_HI;
        end
        sspr_pkg::PH_POS_HI: begin
          pos_hi_nxt = in_byte_r;
          sum_nxt    = sum_r + in_byte_r;
          phase_nxt  = sspr_pkg::PH_CSUM;
        end
        sspr_pkg::PH_CSUM: begin
          frame_done = 1'b1;
          do_store   = csum_ok && id_fits;
          phase_nxt  = sspr_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = sspr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= sspr_pkg::PH_HUNT;
      frame_id_r <= 8'd0;
      sum_r      <= 8'd0;
      pos_lo_r   <= 8'd0;
      pos_hi_r   <= 8'd0;
    end else begin
      phase_r    <= phase_nxt;
      frame_id_r <= frame_id_nxt;
      sum_r      <= sum_nxt;
      pos_lo_r   <= pos_lo_nxt;
      pos_hi_r   <= pos_hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sspr_pkg::NUM_SERVOS; i++) begin
        pos_table_r[i] <= 16'd0;
      end
    end else if (do_store) begin
      pos_table_r[store_idx] <= frame_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (frame_done) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (frame_done) begin
      out_id_r     <= frame_id_r;
      out_pos_r    <= frame_pos;
      out_ok_r     <= csum_ok;
      out_stored_r <= csum_ok && id_fits;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_stored_r, out_ok_r, out_pos_r, out_id_r};

  // A stored frame must have passed its checksum.
  a_stored_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_stored_r || out_ok_r))
    else $error("stored set without checksum_ok");

  // A stored frame leaves its position in the table entry of its id.
  a_table_written: assert property (@(posedge clk) disable iff (!rst_n)
    do_store |=> pos_table_r[$past(store_idx)] == $past(frame_pos))
    else $error("position table entry not updated");

  // A new result only follows a processed checksum byte.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !$past(out_vld_r)) |-> $past(frame_done))
    else $error("result without a completed frame");

  // After the checksum byte the receiver hunts for the next header.
  a_back_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> phase_r == sspr_pkg::PH_HUNT)
    else $error("receiver did not return to header hunt");

  // The input register never drops a byte while the output stalls.
  a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !proc_go) |=> (in_vld_r && in_byte_r == $past(in_byte_r)))
    else $error("buffered byte lost during stall");

endmodule

`default_nettype wire
